FILE: hdl/led_strip_effect_generator_macros.svh
// Assertion macros shared by the LED strip effect generator RTL.
`ifndef LED_STRIP_EFFECT_GENERATOR_MACROS_SVH
`define LED_STRIP_EFFECT_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LSEG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LSEG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/lseg_pkg.sv
// Package with the types, codes and constants of the LED strip effect generator.
`default_nettype none

package lseg_pkg;

   localparam int STRIP_LENGTH_DEFAULT = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam int COLOR_W    = 8;
   localparam int INDEX_W    = 6;
   localparam int MODE_W     = 3;
   localparam int BRIGHT_W   = 7;
   localparam int COUNT_W    = 5;
   localparam int LEVEL_W    = 7;

   // Effect modes.
   localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BREATH  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MARQUEE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SCROLL  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_BLINK   = 3'd5;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] REG_EFFECT_MODE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_BASE_RED    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_BASE_GREEN  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BASE_BLUE   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_BRIGHTNESS  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_LEDS_IN_USE = 3'd5;

   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd40;
   localparam logic [BRIGHT_W-1:0] PERCENT_FULL = 7'd100;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd16;

   localparam logic [LEVEL_W-1:0] BREATH_TOP  = 7'd80;
   localparam logic [LEVEL_W-1:0] BREATH_STEP = 7'd5;

   localparam logic [COLOR_W-1:0] WHEEL_STEP = 8'd5;
   localparam logic [COLOR_W-1:0] WHEEL_SEG1 = 8'd85;
   localparam logic [COLOR_W-1:0] WHEEL_SEG2 = 8'd170;
   localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
   localparam int                 WHEEL_SPAN = 256;

   // Shared restoring divider: a 9-bit dividend, one quotient bit per step.
   localparam int DIV_W     = 9;
   localparam int DIV_CNT_W = 4;

   // x/80 = ((x >> 4) * 1639) >> 13, exact for x up to 255*80.
   localparam int DIV80_PRE    = 4;
   localparam int DIV5_MUL     = 1639;
   localparam int DIV5_SHIFT   = 13;
   localparam int DIV5_PROD_W  = 21;
   // x/100 = ((x >> 2) * 10486) >> 18, exact for x up to 255*100.
   localparam int DIV100_PRE   = 2;
   localparam int DIV25_MUL    = 10486;
   localparam int DIV25_SHIFT  = 18;
   localparam int DIV25_PROD_W = 26;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_WHEEL,
      ST_DIV_POS,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [INDEX_W-1:0] led_index;
      logic               last_pixel;
   } pix_meta_type;

endpackage

`default_nettype wire

FILE: hdl/lseg_ifs.sv
// Channel interfaces of the LED strip effect generator.
`default_nettype none

interface lseg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface lseg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lseg_pkg::INDEX_W-1:0]   led_index;
   logic [lseg_pkg::COLOR_W-1:0]   red;
   logic [lseg_pkg::COLOR_W-1:0]   green;
   logic [lseg_pkg::COLOR_W-1:0]   blue;
   logic                           last_pixel;

   modport source (output valid, output led_index, output red, output green, output blue,
                   output last_pixel, input ready);
   modport sink (input valid, input led_index, input red, input green, input blue,
                 input last_pixel, output ready);
endinterface

interface lseg_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lseg_pkg::CSR_ADDR_W-1:0]   addr;
   logic [lseg_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

FILE: hdl/led_strip_effect_generator.sv
// LED strip effect generator: one frame tick in, one pixel per LED out.
//
// req_chan carries one transaction per frame tick; its restart bit clears the
// breath, wheel, marquee and scroll phases before the frame is drawn.
// rsp_chan delivers STRIP_LENGTH pixel transactions per frame in LED order,
// last_pixel set on the final one. csr_chan writes one register per
// transaction and is always ready; write it only while no frame is in flight.
// After a frame is accepted a shared restoring divider runs twice, nine steps
// each: 256 / used LEDs for the wheel spread, then the next marquee or scroll
// position modulo the used count. Pixels are then issued one per cycle, while
// rsp_chan does not stall, into a five-stage scaling pipeline (breath level,
// /80, brightness, /100, output). req_chan is ready again once the sequencer
// has issued the last pixel and returned to idle. When rsp_chan stalls the
// whole pipeline and the issue sequencer hold. Reset returns the registers to
// their defaults (brightness 40, 16 LEDs in use), zeroes the phases and
// empties the pipeline.
`default_nettype none
`include "led_strip_effect_generator_macros.svh"

module led_strip_effect_generator #(
   parameter int STRIP_LENGTH = lseg_pkg::STRIP_LENGTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   lseg_req_if.sink   req_chan,
   lseg_rsp_if.source rsp_chan,
   lseg_csr_if.sink   csr_chan
);

   localparam int IW   = (STRIP_LENGTH > 1) ? $clog2(STRIP_LENGTH) : 1;
   localparam int UW   = $clog2(STRIP_LENGTH + 1);
   localparam int NCH  = 3;
   localparam int CW   = lseg_pkg::COLOR_W;
   localparam int M1_W = lseg_pkg::COLOR_W + lseg_pkg::LEVEL_W;
   localparam int DW   = lseg_pkg::DIV_W;

   // Sequencer and configuration.
   lseg_pkg::state_type state_ff, state_in;

   logic [lseg_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [CW-1:0]                 red_ff, red_in;
   logic [CW-1:0]                 green_ff, green_in;
   logic [CW-1:0]                 blue_ff, blue_in;
   logic [lseg_pkg::BRIGHT_W-1:0] bright_ff, bright_in;
   logic [lseg_pkg::COUNT_W-1:0]  count_ff, count_in;

   // Effect phases.
   logic [lseg_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic                         rising_ff, rising_in;
   logic [CW-1:0]                wheel_ff, wheel_in;
   logic [lseg_pkg::INDEX_W-1:0] marq_ff, marq_in;
   logic [lseg_pkg::INDEX_W-1:0] scroll_ff, scroll_in;
   logic                         blink_ff, blink_in;

   // Divider and pixel walk.
   logic [DW-1:0]                  div_q_ff, div_q_in;
   logic [UW-1:0]                  div_r_ff, div_r_in;
   logic [lseg_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [CW-1:0]                  step_q_ff, step_q_in;
   logic [UW-1:0]                  step_r_ff, step_r_in;
   logic [lseg_pkg::INDEX_W-1:0]   next_pos_ff, next_pos_in;
   logic [CW-1:0]                  acc_q_ff, acc_q_in;
   logic [UW-1:0]                  acc_r_ff, acc_r_in;
   logic [IW-1:0]                  idx_ff, idx_in;

   // Pixel pipeline.
   logic                         v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lseg_pkg::pix_meta_type       meta0_ff, meta0_in, meta1_ff, meta1_in;
   lseg_pkg::pix_meta_type       meta2_ff, meta2_in, meta3_ff, meta3_in;
   lseg_pkg::pix_meta_type       rsp_meta_ff, rsp_meta_in;
   logic [CW-1:0]                col0_ff [NCH];
   logic [CW-1:0]                col0_in [NCH];
   logic [lseg_pkg::LEVEL_W-1:0] lvl0_ff, lvl0_in;
   logic [M1_W-1:0]              m1_ff [NCH];
   logic [M1_W-1:0]              m1_in [NCH];
   logic [CW-1:0]                q80_ff [NCH];
   logic [CW-1:0]                q80_in [NCH];
   logic [M1_W-1:0]              m2_ff [NCH];
   logic [M1_W-1:0]              m2_in [NCH];
   logic [CW-1:0]                rsp_col_ff [NCH];
   logic [CW-1:0]                rsp_col_in [NCH];

   // Combinational helpers.
   logic [UW-1:0]                used;
   logic [lseg_pkg::BRIGHT_W-1:0] bright;
   logic                         adv;
   logic                         req_ready;
   logic [UW:0]                  div_t;
   logic                         div_ge;
   logic [UW-1:0]                div_r_step;
   logic [DW-1:0]                div_q_step;
   logic [lseg_pkg::INDEX_W-1:0] pos_sel;
   logic [UW:0]                  acc_sum;
   logic                         acc_wrap;
   logic                         last_idx;
   logic [CW-1:0]                wheel_col [NCH];
   logic [CW-1:0]                base_col [NCH];
   logic [CW-1:0]                pix_col [NCH];
   logic [lseg_pkg::LEVEL_W-1:0] pix_lvl;
   logic [lseg_pkg::INDEX_W-1:0] idx_ext;

   // Used LED count with out-of-range values folded in.
   always_comb begin
      if (count_ff == '0) begin
         used = UW'(1);
      end else if (int'(count_ff) > STRIP_LENGTH) begin
         used = UW'(STRIP_LENGTH);
      end else begin
         used = UW'(count_ff);
      end
   end

   assign bright = (bright_ff > lseg_pkg::PERCENT_FULL) ? lseg_pkg::PERCENT_FULL : bright_ff;
   assign adv    = !rsp_valid_ff || rsp_chan.ready;

   // One restoring division step: shift in the next dividend bit, subtract if it fits.
   assign div_t      = {div_r_ff, div_q_ff[DW-1]};
   assign div_ge     = div_t >= {1'b0, used};
   assign div_r_step = div_ge ? UW'(div_t - {1'b0, used}) : div_t[UW-1:0];
   assign div_q_step = {div_q_ff[DW-2:0], div_ge};

   assign pos_sel  = (mode_ff == lseg_pkg::MODE_SCROLL) ? scroll_ff : marq_ff;
   assign acc_sum  = {1'b0, acc_r_ff} + {1'b0, step_r_ff};
   assign acc_wrap = acc_sum >= {1'b0, used};
   assign last_idx = idx_ff == IW'(STRIP_LENGTH - 1);
   assign idx_ext  = lseg_pkg::INDEX_W'(idx_ff);

   // Configuration writes.
   assign csr_chan.ready = 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      bright_in = bright_ff;
      count_in  = count_ff;
      if (csr_chan.valid) begin
         case (csr_chan.addr)
            lseg_pkg::REG_EFFECT_MODE: mode_in   = csr_chan.wdata[lseg_pkg::MODE_W-1:0];
            lseg_pkg::REG_BASE_RED:    red_in    = csr_chan.wdata[CW-1:0];
            lseg_pkg::REG_BASE_GREEN:  green_in  = csr_chan.wdata[CW-1:0];
            lseg_pkg::REG_BASE_BLUE:   blue_in   = csr_chan.wdata[CW-1:0];
            lseg_pkg::REG_BRIGHTNESS:  bright_in = csr_chan.wdata[lseg_pkg::BRIGHT_W-1:0];
            lseg_pkg::REG_LEDS_IN_USE: count_in  = csr_chan.wdata[lseg_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer: accept, two divisions, then one pixel issued per advancing cycle.
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      level_in    = level_ff;
      rising_in   = rising_ff;
      wheel_in    = wheel_ff;
      marq_in     = marq_ff;
      scroll_in   = scroll_ff;
      blink_in    = blink_ff;
      div_q_in    = div_q_ff;
      div_r_in    = div_r_ff;
      div_cnt_in  = div_cnt_ff;
      step_q_in   = step_q_ff;
      step_r_in   = step_r_ff;
      next_pos_in = next_pos_ff;
      acc_q_in    = acc_q_ff;
      acc_r_in    = acc_r_ff;
      idx_in      = idx_ff;

      case (state_ff)
         lseg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               state_in   = lseg_pkg::ST_DIV_WHEEL;
               div_q_in   = DW'(lseg_pkg::WHEEL_SPAN);
               div_r_in   = '0;
               div_cnt_in = '0;
               if (req_chan.restart) begin
                  level_in  = '0;
                  rising_in = 1'b1;
                  wheel_in  = '0;
                  marq_in   = '0;
                  scroll_in = '0;
               end else if (level_ff > lseg_pkg::BREATH_TOP) begin
                  level_in = lseg_pkg::BREATH_TOP;
               end
            end
         end
         lseg_pkg::ST_DIV_WHEEL: begin
            div_q_in   = div_q_step;
            div_r_in   = div_r_step;
            div_cnt_in = div_cnt_ff + lseg_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == lseg_pkg::DIV_CNT_W'(DW - 1)) begin
               step_q_in  = div_q_step[CW-1:0];
               step_r_in  = div_r_step;
               div_q_in   = DW'(pos_sel) + DW'(1);
               div_r_in   = '0;
               div_cnt_in = '0;
               state_in   = lseg_pkg::ST_DIV_POS;
            end
         end
         lseg_pkg::ST_DIV_POS: begin
            div_q_in   = div_q_step;
            div_r_in   = div_r_step;
            div_cnt_in = div_cnt_ff + lseg_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == lseg_pkg::DIV_CNT_W'(DW - 1)) begin
               next_pos_in = lseg_pkg::INDEX_W'(div_r_step);
               acc_q_in    = wheel_ff;
               acc_r_in    = '0;
               idx_in      = '0;
               state_in    = lseg_pkg::ST_EMIT;
            end
         end
         lseg_pkg::ST_EMIT: begin
            if (adv) begin
               // The wheel offset i*256/u advances by quotient and remainder.
               acc_r_in = acc_wrap ? UW'(acc_sum - {1'b0, used}) : acc_sum[UW-1:0];
               acc_q_in = acc_q_ff + step_q_ff + CW'(acc_wrap);
               idx_in   = idx_ff + IW'(1);
               if (last_idx) begin
                  state_in = lseg_pkg::ST_IDLE;
                  case (mode_ff)
                     lseg_pkg::MODE_BREATH: begin
                        if (rising_ff) begin
                           if (level_ff + lseg_pkg::BREATH_STEP >= lseg_pkg::BREATH_TOP) begin
                              level_in  = lseg_pkg::BREATH_TOP;
                              rising_in = 1'b0;
                           end else begin
                              level_in = level_ff + lseg_pkg::BREATH_STEP;
                           end
                        end else if (level_ff <= lseg_pkg::BREATH_STEP) begin
                           level_in  = '0;
                           rising_in = 1'b1;
                        end else begin
                           level_in = level_ff - lseg_pkg::BREATH_STEP;
                        end
                     end
                     lseg_pkg::MODE_RAINBOW: wheel_in  = wheel_ff + lseg_pkg::WHEEL_STEP;
                     lseg_pkg::MODE_MARQUEE: marq_in   = next_pos_ff;
                     lseg_pkg::MODE_SCROLL:  scroll_in = next_pos_ff;
                     lseg_pkg::MODE_BLINK:   blink_in  = !blink_ff;
                     default: begin
                     end
                  endcase
               end
            end
         end
         default: state_in = lseg_pkg::ST_IDLE;
      endcase
   end

   assign req_chan.ready = req_ready;

   // Three-segment colour wheel at the current offset.
   always_comb begin
      logic [CW-1:0] seg;
      logic [CW:0]   tri3;
      if (acc_q_ff < lseg_pkg::WHEEL_SEG1) begin
         seg = acc_q_ff;
      end else if (acc_q_ff < lseg_pkg::WHEEL_SEG2) begin
         seg = acc_q_ff - lseg_pkg::WHEEL_SEG1;
      end else begin
         seg = acc_q_ff - lseg_pkg::WHEEL_SEG2;
      end
      tri3 = {1'b0, seg} + {seg, 1'b0};
      if (acc_q_ff < lseg_pkg::WHEEL_SEG1) begin
         wheel_col[0] = tri3[CW-1:0];
         wheel_col[1] = lseg_pkg::COLOR_FULL - tri3[CW-1:0];
         wheel_col[2] = '0;
      end else if (acc_q_ff < lseg_pkg::WHEEL_SEG2) begin
         wheel_col[0] = lseg_pkg::COLOR_FULL - tri3[CW-1:0];
         wheel_col[1] = '0;
         wheel_col[2] = tri3[CW-1:0];
      end else begin
         wheel_col[0] = '0;
         wheel_col[1] = tri3[CW-1:0];
         wheel_col[2] = lseg_pkg::COLOR_FULL - tri3[CW-1:0];
      end
   end

   // Raw pixel colour and breath level for the LED being issued.
   always_comb begin
      base_col[0] = red_ff;
      base_col[1] = green_ff;
      base_col[2] = blue_ff;
      pix_lvl     = lseg_pkg::BREATH_TOP;
      for (int ch = 0; ch < NCH; ch++) begin
         pix_col[ch] = '0;
      end
      if (int'(idx_ff) < int'(used)) begin
         case (mode_ff)
            lseg_pkg::MODE_BREATH: begin
               pix_lvl = level_ff;
               for (int ch = 0; ch < NCH; ch++) begin
                  pix_col[ch] = base_col[ch];
               end
            end
            lseg_pkg::MODE_RAINBOW: begin
               for (int ch = 0; ch < NCH; ch++) begin
                  pix_col[ch] = wheel_col[ch];
               end
            end
            lseg_pkg::MODE_MARQUEE, lseg_pkg::MODE_SCROLL: begin
               if (idx_ext == pos_sel) begin
                  for (int ch = 0; ch < NCH; ch++) begin
                     pix_col[ch] = base_col[ch];
                  end
               end
            end
            lseg_pkg::MODE_BLINK: begin
               if (blink_ff) begin
                  for (int ch = 0; ch < NCH; ch++) begin
                     pix_col[ch] = base_col[ch];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Scaling pipeline; every stage moves together whenever the output can advance.
   always_comb begin
      logic [lseg_pkg::DIV5_PROD_W-1:0]  prod5;
      logic [lseg_pkg::DIV25_PROD_W-1:0] prod25;
      prod5        = '0;
      prod25       = '0;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      v3_in        = v3_ff;
      rsp_valid_in = rsp_valid_ff;
      meta0_in     = meta0_ff;
      meta1_in     = meta1_ff;
      meta2_in     = meta2_ff;
      meta3_in     = meta3_ff;
      rsp_meta_in  = rsp_meta_ff;
      lvl0_in      = lvl0_ff;
      for (int ch = 0; ch < NCH; ch++) begin
         col0_in[ch]    = col0_ff[ch];
         m1_in[ch]      = m1_ff[ch];
         q80_in[ch]     = q80_ff[ch];
         m2_in[ch]      = m2_ff[ch];
         rsp_col_in[ch] = rsp_col_ff[ch];
      end
      if (adv) begin
         v0_in                = state_ff == lseg_pkg::ST_EMIT;
         v1_in                = v0_ff;
         v2_in                = v1_ff;
         v3_in                = v2_ff;
         rsp_valid_in         = v3_ff;
         meta0_in.led_index   = idx_ext;
         meta0_in.last_pixel  = last_idx;
         meta1_in             = meta0_ff;
         meta2_in             = meta1_ff;
         meta3_in             = meta2_ff;
         rsp_meta_in          = meta3_ff;
         lvl0_in              = pix_lvl;
         for (int ch = 0; ch < NCH; ch++) begin
            col0_in[ch]    = pix_col[ch];
            m1_in[ch]      = M1_W'(col0_ff[ch]) * M1_W'(lvl0_ff);
            prod5          = lseg_pkg::DIV5_PROD_W'(m1_ff[ch][M1_W-1:lseg_pkg::DIV80_PRE])
                             * lseg_pkg::DIV5_PROD_W'(lseg_pkg::DIV5_MUL);
            q80_in[ch]     = prod5[lseg_pkg::DIV5_SHIFT +: CW];
            m2_in[ch]      = M1_W'(q80_ff[ch]) * M1_W'(bright);
            prod25         = lseg_pkg::DIV25_PROD_W'(m2_ff[ch][M1_W-1:lseg_pkg::DIV100_PRE])
                             * lseg_pkg::DIV25_PROD_W'(lseg_pkg::DIV25_MUL);
            rsp_col_in[ch] = prod25[lseg_pkg::DIV25_SHIFT +: CW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lseg_pkg::ST_IDLE;
         mode_ff      <= lseg_pkg::MODE_OFF;
         red_ff       <= '0;
         green_ff     <= '0;
         blue_ff      <= '0;
         bright_ff    <= lseg_pkg::BRIGHT_RESET;
         count_ff     <= lseg_pkg::COUNT_RESET;
         level_ff     <= '0;
         rising_ff    <= 1'b1;
         wheel_ff     <= '0;
         marq_ff      <= '0;
         scroll_ff    <= '0;
         blink_ff     <= 1'b0;
         div_cnt_ff   <= '0;
         idx_ff       <= '0;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         bright_ff    <= bright_in;
         count_ff     <= count_in;
         level_ff     <= level_in;
         rising_ff    <= rising_in;
         wheel_ff     <= wheel_in;
         marq_ff      <= marq_in;
         scroll_ff    <= scroll_in;
         blink_ff     <= blink_in;
         div_cnt_ff   <= div_cnt_in;
         idx_ff       <= idx_in;
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_q_ff    <= div_q_in;
      div_r_ff    <= div_r_in;
      step_q_ff   <= step_q_in;
      step_r_ff   <= step_r_in;
      next_pos_ff <= next_pos_in;
      acc_q_ff    <= acc_q_in;
      acc_r_ff    <= acc_r_in;
      meta0_ff    <= meta0_in;
      meta1_ff    <= meta1_in;
      meta2_ff    <= meta2_in;
      meta3_ff    <= meta3_in;
      rsp_meta_ff <= rsp_meta_in;
      lvl0_ff     <= lvl0_in;
      for (int ch = 0; ch < NCH; ch++) begin
         col0_ff[ch]    <= col0_in[ch];
         m1_ff[ch]      <= m1_in[ch];
         q80_ff[ch]     <= q80_in[ch];
         m2_ff[ch]      <= m2_in[ch];
         rsp_col_ff[ch] <= rsp_col_in[ch];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.led_index  = rsp_meta_ff.led_index;
   assign rsp_chan.last_pixel = rsp_meta_ff.last_pixel;
   assign rsp_chan.red        = rsp_col_ff[0];
   assign rsp_chan.green      = rsp_col_ff[1];
   assign rsp_chan.blue       = rsp_col_ff[2];

   `LSEG_ASSERT_IMPLIES(a_last_on_final_led, clock, reset, rsp_valid_ff && rsp_meta_ff.last_pixel, rsp_meta_ff.led_index == lseg_pkg::INDEX_W'(STRIP_LENGTH - 1), "last pixel flagged on the wrong LED")
   `LSEG_ASSERT_IMPLIES(a_breath_in_range, clock, reset, 1'b1, level_ff <= lseg_pkg::BREATH_TOP, "breath level above its top")
   `LSEG_ASSERT_IMPLIES(a_wheel_rem_below_used, clock, reset, state_ff == lseg_pkg::ST_EMIT, acc_r_ff < used, "wheel remainder not below used count")
   `LSEG_ASSERT_NEXT(a_frame_starts_division, clock, reset, req_chan.valid && req_chan.ready, state_ff == lseg_pkg::ST_DIV_WHEEL, "accepted frame did not start the divider")

endmodule

`default_nettype wire

FILE: test/led_strip_effect_generator_tb.sv
// Self-checking testbench for the LED strip effect generator: directed table, then random phases.
module led_strip_effect_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lseg_pkg::*;

   localparam int STRIP      = STRIP_LENGTH_DEFAULT;
   localparam int DRAIN      = 48;
   localparam int LONG_HOLD  = 320;
   localparam int RANDOM_FRAMES = 100;
   localparam int QUIET_FRAMES  = 25;

   // Mode codes that the block does not use; they must behave as off.
   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [INDEX_W-1:0] led_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               last_pixel;
   } pixel_type;

   typedef enum {ROW_WRITE, ROW_FRAME} row_op_type;
   typedef enum {CHK_MODEL, CHK_DARK, CHK_SOLID} check_kind_type;

   typedef struct {
      row_op_type             op;
      logic [CSR_ADDR_W-1:0]  addr;
      logic [CSR_DATA_W-1:0]  data;
      logic                   restart;
      check_kind_type         chk;
      logic [COLOR_W-1:0]     red;
      logic [COLOR_W-1:0]     green;
      logic [COLOR_W-1:0]     blue;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lseg_req_if req_chan ();
   lseg_rsp_if rsp_chan ();
   lseg_csr_if csr_chan ();

   led_strip_effect_generator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #10 clock = ~clock;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // Shadow copy of the registers and the effect phases.
   logic [MODE_W-1:0]   mode_reg   = MODE_OFF;
   logic [COLOR_W-1:0]  red_reg    = '0;
   logic [COLOR_W-1:0]  green_reg  = '0;
   logic [COLOR_W-1:0]  blue_reg   = '0;
   logic [BRIGHT_W-1:0] bright_reg = BRIGHT_RESET;
   logic [COUNT_W-1:0]  count_reg  = COUNT_RESET;

   logic [LEVEL_W-1:0]  level        = '0;
   logic                rising       = 1'b1;
   logic [COLOR_W-1:0]  wheel_base   = '0;
   logic [INDEX_W-1:0]  marquee_spot = '0;
   logic [INDEX_W-1:0]  scroll_pos   = '0;
   logic                blink_lit    = 1'b0;

   pixel_type    rendered [STRIP];
   pixel_type    expected_pixels [$];
   stim_row_type stim_plan [$];

   int  errors = 0;
   int  pixels_checked = 0;
   int  frames_sent = 0;
   int  restarts_sent = 0;
   int  mode_frames [8];
   bit  quiet = 1'b0;
   bit  hold_request = 1'b0;

   task automatic flag_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
   endtask

   function automatic int unsigned used_leds();
      int unsigned u;
      u = 32'(count_reg);
      if (u == 0) u = 1;
      if (u > STRIP) u = STRIP;
      return u;
   endfunction

   function automatic logic [COLOR_W-1:0] dim(input int unsigned c);
      int unsigned pct;
      pct = (bright_reg > PERCENT_FULL) ? 32'(PERCENT_FULL) : 32'(bright_reg);
      return COLOR_W'((c % WHEEL_SPAN) * pct / PERCENT_FULL);
   endfunction

   // Draws one frame into rendered[] and then steps the phase of the active mode.
   task automatic render_frame(input logic restart);
      int unsigned u, p, q, r, g, b, pos;
      u = used_leds();
      if (restart) begin
         level        = '0;
         rising       = 1'b1;
         wheel_base   = '0;
         marquee_spot = '0;
         scroll_pos   = '0;
      end
      if (level > BREATH_TOP) level = BREATH_TOP;

      for (int unsigned i = 0; i < STRIP; i++) begin
         r = 0; g = 0; b = 0;
         if (i < u) begin
            case (mode_reg)
               MODE_BREATH: begin
                  r = dim(32'(red_reg) * level / BREATH_TOP);
                  g = dim(32'(green_reg) * level / BREATH_TOP);
                  b = dim(32'(blue_reg) * level / BREATH_TOP);
               end
               MODE_RAINBOW: begin
                  p = (wheel_base + i * WHEEL_SPAN / u) % WHEEL_SPAN;
                  if (p < WHEEL_SEG1) begin
                     r = 3 * p; g = COLOR_FULL - 3 * p; b = 0;
                  end else if (p < WHEEL_SEG2) begin
                     q = p - WHEEL_SEG1;
                     r = COLOR_FULL - 3 * q; g = 0; b = 3 * q;
                  end else begin
                     q = p - WHEEL_SEG2;
                     r = 0; g = 3 * q; b = COLOR_FULL - 3 * q;
                  end
                  r = dim(r); g = dim(g); b = dim(b);
               end
               MODE_MARQUEE, MODE_SCROLL: begin
                  pos = (mode_reg == MODE_MARQUEE) ? 32'(marquee_spot) : 32'(scroll_pos);
                  if (i == pos) begin
                     r = dim(red_reg); g = dim(green_reg); b = dim(blue_reg);
                  end
               end
               MODE_BLINK: begin
                  if (blink_lit) begin
                     r = dim(red_reg); g = dim(green_reg); b = dim(blue_reg);
                  end
               end
               default: ;
            endcase
         end
         rendered[i].led_index  = INDEX_W'(i);
         rendered[i].red        = COLOR_W'(r);
         rendered[i].green      = COLOR_W'(g);
         rendered[i].blue       = COLOR_W'(b);
         rendered[i].last_pixel = (i == STRIP - 1);
      end

      case (mode_reg)
         MODE_BREATH: begin
            if (rising) begin
               if (level + BREATH_STEP >= BREATH_TOP) begin
                  level  = BREATH_TOP;
                  rising = 1'b0;
               end else begin
                  level = level + BREATH_STEP;
               end
            end else if (level <= BREATH_STEP) begin
               level  = '0;
               rising = 1'b1;
            end else begin
               level = level - BREATH_STEP;
            end
         end
         MODE_RAINBOW: wheel_base = wheel_base + WHEEL_STEP;
         MODE_MARQUEE: marquee_spot = INDEX_W'((marquee_spot + 1) % u);
         MODE_SCROLL:  scroll_pos = INDEX_W'((scroll_pos + 1) % u);
         MODE_BLINK:   blink_lit = ~blink_lit;
         default: ;
      endcase
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.addr  <= addr;
      csr_chan.wdata <= data;
      do @(posedge clock); while (!csr_chan.ready);
      case (addr)
         REG_EFFECT_MODE: mode_reg   = data[MODE_W-1:0];
         REG_BASE_RED:    red_reg    = data;
         REG_BASE_GREEN:  green_reg  = data;
         REG_BASE_BLUE:   blue_reg   = data;
         REG_BRIGHTNESS:  bright_reg = data[BRIGHT_W-1:0];
         REG_LEDS_IN_USE: count_reg  = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // Offers one frame tick; the valid line stays high on return so that a
   // following frame can go out back to back.
   task automatic send_frame(input logic restart, input check_kind_type chk,
                             input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                             input logic [COLOR_W-1:0] b);
      int unsigned u;
      pixel_type px;
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.restart <= restart;
      do @(posedge clock); while (!req_chan.ready);

      frames_sent++;
      if (restart) restarts_sent++;
      mode_frames[mode_reg]++;
      u = used_leds();
      render_frame(restart);
      for (int unsigned i = 0; i < STRIP; i++) begin
         px = rendered[i];
         if (chk != CHK_MODEL) begin
            if (chk == CHK_SOLID && i < u) begin
               px.red = r; px.green = g; px.blue = b;
            end else begin
               px.red = '0; px.green = '0; px.blue = '0;
            end
         end
         expected_pixels.push_back(px);
      end
   endtask

   // Waits until every pixel is out and the pipeline has had time to empty.
   task automatic settle();
      int guard;
      guard = 0;
      req_chan.valid <= 1'b0;
      while (expected_pixels.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic plan_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{ROW_WRITE, addr, data, 1'b0, CHK_MODEL, '0, '0, '0};
      stim_plan.push_back(row);
   endtask

   task automatic plan_frame(input logic restart, input check_kind_type chk,
                             input logic [COLOR_W-1:0] r = '0,
                             input logic [COLOR_W-1:0] g = '0,
                             input logic [COLOR_W-1:0] b = '0);
      stim_row_type row;
      row = '{ROW_FRAME, '0, '0, restart, chk, r, g, b};
      stim_plan.push_back(row);
   endtask

   // Receiver: short random stalls, and one long hold-off on request.
   initial begin
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_pixels.size() == 0) begin
            flag_error($sformatf("pixel transaction for led %0d with no frame pending",
                                 rsp_chan.led_index));
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_chan.led_index !== want.led_index)
               flag_error($sformatf("led_index %0d, expected %0d",
                                    rsp_chan.led_index, want.led_index));
            if (rsp_chan.red !== want.red)
               flag_error($sformatf("led %0d red %0d, expected %0d",
                                    want.led_index, rsp_chan.red, want.red));
            if (rsp_chan.green !== want.green)
               flag_error($sformatf("led %0d green %0d, expected %0d",
                                    want.led_index, rsp_chan.green, want.green));
            if (rsp_chan.blue !== want.blue)
               flag_error($sformatf("led %0d blue %0d, expected %0d",
                                    want.led_index, rsp_chan.blue, want.blue));
            if (rsp_chan.last_pixel !== want.last_pixel)
               flag_error($sformatf("led %0d last_pixel %0b, expected %0b",
                                    want.led_index, rsp_chan.last_pixel, want.last_pixel));
         end
      end
   end

   initial begin : stimulus
      bit in_flight;
      int rand_frames, phase, len;
      logic [MODE_W-1:0] mode_pick;
      logic [CSR_DATA_W-1:0] value;

      req_chan.valid   <= 1'b0;
      req_chan.restart <= 1'b0;
      csr_chan.valid   <= 1'b0;
      csr_chan.addr    <= '0;
      csr_chan.wdata   <= '0;
      in_flight = 1'b0;

      // Reset state, blink with full white, brightness at zero and above range,
      // the unused mode codes, then each effect with short frame runs.
      plan_frame(1'b0, CHK_DARK);
      plan_write(REG_EFFECT_MODE, CSR_DATA_W'(MODE_BLINK));
      plan_write(REG_BASE_RED, 8'hFF);
      plan_write(REG_BASE_GREEN, 8'hFF);
      plan_write(REG_BASE_BLUE, 8'hFF);
      plan_write(REG_BRIGHTNESS, CSR_DATA_W'(PERCENT_FULL));
      plan_frame(1'b0, CHK_DARK);
      plan_frame(1'b0, CHK_SOLID, 8'hFF, 8'hFF, 8'hFF);
      plan_write(REG_BRIGHTNESS, 8'd0);
      plan_frame(1'b0, CHK_DARK);
      plan_frame(1'b0, CHK_DARK);
      plan_write(REG_BRIGHTNESS, 8'd127);
      plan_frame(1'b0, CHK_DARK);
      plan_frame(1'b0, CHK_SOLID, 8'hFF, 8'hFF, 8'hFF);
      plan_write(REG_EFFECT_MODE, CSR_DATA_W'(MODE_SPARE_6));
      plan_frame(1'b0, CHK_DARK);
      plan_write(REG_EFFECT_MODE, CSR_DATA_W'(MODE_SPARE_7));
      plan_frame(1'b1, CHK_DARK);
      plan_write(REG_EFFECT_MODE, CSR_DATA_W'(MODE_BREATH));
      plan_write(REG_BASE_RED, 8'd200);
      plan_write(REG_BASE_GREEN, 8'd100);
      plan_write(REG_BASE_BLUE, 8'd1);
      plan_write(REG_BRIGHTNESS, CSR_DATA_W'(PERCENT_FULL));
      plan_frame(1'b1, CHK_DARK);
      plan_frame(1'b0, CHK_MODEL);
      plan_frame(1'b0, CHK_MODEL);
      // A used count of zero counts as one LED; the wheel starts on pure green.
      plan_write(REG_EFFECT_MODE, CSR_DATA_W'(MODE_RAINBOW));
      plan_write(REG_LEDS_IN_USE, 8'd0);
      plan_frame(1'b1, CHK_SOLID, 8'd0, COLOR_FULL, 8'd0);
      plan_write(REG_LEDS_IN_USE, 8'd31);
      plan_frame(1'b0, CHK_MODEL);
      plan_write(REG_LEDS_IN_USE, 8'd3);
      plan_frame(1'b0, CHK_MODEL);
      // Marquee left at position 3, then the used count drops below it.
      plan_write(REG_EFFECT_MODE, CSR_DATA_W'(MODE_MARQUEE));
      plan_write(REG_LEDS_IN_USE, 8'd16);
      plan_frame(1'b1, CHK_MODEL);
      plan_frame(1'b0, CHK_MODEL);
      plan_frame(1'b0, CHK_MODEL);
      plan_write(REG_LEDS_IN_USE, 8'd2);
      plan_frame(1'b0, CHK_DARK);
      plan_frame(1'b0, CHK_MODEL);
      plan_write(REG_EFFECT_MODE, CSR_DATA_W'(MODE_SCROLL));
      plan_write(REG_LEDS_IN_USE, 8'd5);
      plan_frame(1'b1, CHK_MODEL);
      plan_frame(1'b0, CHK_MODEL);

      while (reset) @(posedge clock);

      foreach (stim_plan[k]) begin
         if (stim_plan[k].op == ROW_WRITE) begin
            if (in_flight) begin
               settle();
               in_flight = 1'b0;
            end
            csr_write(stim_plan[k].addr, stim_plan[k].data);
         end else begin
            csr_chan.valid <= 1'b0;
            send_frame(stim_plan[k].restart, stim_plan[k].chk, stim_plan[k].red,
                       stim_plan[k].green, stim_plan[k].blue);
            in_flight = 1'b1;
         end
      end

      // Random phases: a fresh setting, then a run of consecutive frames so
      // that breath and the moving dot step through successive positions.
      rand_frames = 0;
      phase = 0;
      while (rand_frames < RANDOM_FRAMES) begin
         settle();
         mode_pick = MODE_W'($urandom_range(0, 7));
         if ($urandom_range(0, 3) != 0)
            mode_pick = MODE_W'($urandom_range(MODE_BREATH, MODE_BLINK));
         csr_write(REG_EFFECT_MODE, CSR_DATA_W'(mode_pick));
         if ($urandom_range(0, 1)) csr_write(REG_BASE_RED, CSR_DATA_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) csr_write(REG_BASE_GREEN, CSR_DATA_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) csr_write(REG_BASE_BLUE, CSR_DATA_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) begin
            value = ($urandom_range(0, 5) == 0) ? CSR_DATA_W'($urandom_range(101, 127))
                                                : CSR_DATA_W'($urandom_range(0, 100));
            csr_write(REG_BRIGHTNESS, value);
         end
         if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 7) == 0)
               value = $urandom_range(0, 1) ? CSR_DATA_W'(0) : CSR_DATA_W'($urandom_range(17, 31));
            else
               value = CSR_DATA_W'($urandom_range(1, 16));
            csr_write(REG_LEDS_IN_USE, value);
         end
         csr_chan.valid <= 1'b0;

         // The second phase runs into a long receiver hold-off, so the
         // block fills up and stops taking frames.
         if (phase == 1) hold_request = 1'b1;
         if (rand_frames >= RANDOM_FRAMES - QUIET_FRAMES) quiet = 1'b1;
         len = $urandom_range(4, 20);
         if (len > RANDOM_FRAMES - rand_frames) len = RANDOM_FRAMES - rand_frames;
         repeat (len) begin
            send_frame($urandom_range(0, 9) == 0, CHK_MODEL, '0, '0, '0);
            rand_frames++;
         end
         phase++;
      end

      settle();
      if (expected_pixels.size() != 0)
         flag_error($sformatf("%0d expected pixels never arrived", expected_pixels.size()));

      $display("Run covered %0d frame ticks (%0d with restart), %0d pixels compared.",
               frames_sent, restarts_sent, pixels_checked);
      $display("Frames per mode: off %0d, breath %0d, rainbow %0d, marquee %0d, scroll %0d, blink %0d, unused %0d.",
               mode_frames[MODE_OFF], mode_frames[MODE_BREATH], mode_frames[MODE_RAINBOW],
               mode_frames[MODE_MARQUEE], mode_frames[MODE_SCROLL], mode_frames[MODE_BLINK],
               mode_frames[MODE_SPARE_6] + mode_frames[MODE_SPARE_7]);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
